FILE: sv/fpst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_pkg
// Request codes, field widths and register reset value of the prefix-sum table.
// ----------------------------------------------------------------------------
package fpst_pkg;

  localparam int MODE_W  = 3;
  localparam int IDX_W   = 11;
  localparam int SIDX_W  = 10;
  localparam int AMT_W   = 48;
  localparam int FOUND_W = 12;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 64;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [IDX_W-1:0]  size_t;

  localparam mode_t MODE_ADD    = 3'd0;
  localparam mode_t MODE_PREFIX = 3'd1;
  localparam mode_t MODE_RANGE  = 3'd2;
  localparam mode_t MODE_POINT  = 3'd3;
  localparam mode_t MODE_SEARCH = 3'd4;

  localparam size_t SIZE_RESET = 11'd1024;

endpackage

FILE: sv/fpst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpst_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fenwick_prefix_sum_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table
// Binary indexed tree of signed partial sums held in one RAM.
// ----------------------------------------------------------------------------
// One request is worked at a time against a single RAM with one read and one
// write port. An add walks its update chain at one entry per cycle (read of
// the next entry overlaps the write-back of the current one). Prefix, range
// and point sums stream their index chains through the read port, one entry
// per cycle, and subtract a second chain when it is non-empty. A lower-bound
// search makes one dependent read and compare per probe. After reset and
// after every write of entries_in_use the block clears the RAM, one entry a
// cycle over all ENTRIES entries, and accepts no request meanwhile. A
// finished result waits in the output register while the next request is
// taken.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table #(
  parameter int ENTRIES   = 1024,
  parameter int SUM_WIDTH = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // first_index[10:0], second_index[20:11], amount[68:21], zero fill
  input  logic [fpst_pkg::IN_W-1:0]       s_axis_tdata,
  // mode[2:0]
  input  fpst_pkg::mode_t                 s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // sum_result[47:0], found_position[59:48], zero fill
  output logic [fpst_pkg::OUT_W-1:0]      m_axis_tdata,
  // bad_index[0]
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  fpst_pkg::size_t                 cfg_data
);

  import fpst_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int NW = $clog2(ENTRIES + 1);
  localparam int PW = NW + 1;
  localparam int CW = ((NW > IDX_W) ? NW : IDX_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [NW-1:0] TOP_STEP  = {1'b1, {(NW-1){1'b0}}};

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_SRCH  = 3'd4;
  localparam logic [2:0] ST_SCMP  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]           state, state_next;
  size_t                entries_in_use;
  logic [AW-1:0]        clr;
  logic [PW-1:0]        pos, pos_next;
  logic [NW-1:0]        other_end, other_end_next;
  logic                 on_b, on_b_next;
  logic                 rd_pend, rd_pend_next;
  logic                 rd_sub, rd_sub_next;
  logic [SUM_WIDTH-1:0] acc, acc_next;
  logic [SUM_WIDTH-1:0] operand, operand_next;
  logic [NW-1:0]        step, step_next;
  logic [FOUND_W-1:0]   res_found, res_found_next;
  logic                 res_bad, res_bad_next;
  logic [AMT_W-1:0]     m_sum;
  logic [FOUND_W-1:0]   m_found;
  logic                 m_bad;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [SUM_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                 s_accept, cfg_accept, out_load;
  logic [CW-1:0]        n_w, first_w, second_w, first_inc, second_inc;
  logic [NW-1:0]        n;
  logic [63:0]          amt64, sum64;
  logic [SUM_WIDTH-1:0] amt_sw;
  logic [PW-1:0]        add_nxt, pos_dec, cand, cand_dec;

  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_load   = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  assign n_w        = (CW'(entries_in_use) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(entries_in_use);
  assign n          = n_w[NW-1:0];
  assign first_w    = CW'(s_axis_tdata[10:0]);
  assign second_w   = CW'(s_axis_tdata[20:11]);
  assign first_inc  = first_w + CW'(1);
  assign second_inc = second_w + CW'(1);
  assign amt64      = {{(64-AMT_W){s_axis_tdata[68]}}, s_axis_tdata[68:21]};
  assign amt_sw     = amt64[SUM_WIDTH-1:0];

  assign add_nxt    = pos | (pos + PW'(1));
  assign pos_dec    = pos - PW'(1);
  assign cand       = pos + {1'b0, step};
  assign cand_dec   = cand - PW'(1);
  assign sum64      = 64'($signed(acc));

  fpst_ram #(
    .WIDTH(SUM_WIDTH),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    other_end_next = other_end;
    on_b_next      = on_b;
    rd_pend_next   = rd_pend;
    rd_sub_next    = rd_sub;
    acc_next       = acc;
    operand_next   = operand;
    step_next      = step;
    res_found_next = res_found;
    res_bad_next   = res_bad;
    ram_we         = 1'b0;
    ram_waddr      = clr;
    ram_wdata      = '0;
    ram_raddr      = pos[AW-1:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          acc_next       = '0;
          res_found_next = '0;
          res_bad_next   = 1'b0;
          operand_next   = amt_sw;
          on_b_next      = 1'b0;
          rd_pend_next   = 1'b0;
          step_next      = TOP_STEP;
          pos_next       = '0;
          state_next     = ST_DONE;
          unique case (s_axis_tuser)
            MODE_ADD: begin
              if (first_w >= n_w) begin
                res_bad_next = 1'b1;
              end else begin
                ram_raddr  = first_w[AW-1:0];
                pos_next   = first_w[PW-1:0];
                state_next = ST_ADD;
              end
            end
            MODE_PREFIX: begin
              if (first_w > n_w) begin
                res_bad_next = 1'b1;
              end else begin
                pos_next       = first_w[PW-1:0];
                other_end_next = '0;
                state_next     = ST_SUM;
              end
            end
            MODE_RANGE: begin
              if (first_w >= n_w || second_w >= n_w) begin
                res_bad_next = 1'b1;
              end else begin
                pos_next       = second_inc[PW-1:0];
                other_end_next = first_w[NW-1:0];
                state_next     = ST_SUM;
              end
            end
            MODE_POINT: begin
              if (first_w >= n_w) begin
                res_bad_next = 1'b1;
              end else begin
                pos_next       = first_inc[PW-1:0];
                other_end_next = first_w[NW-1:0];
                state_next     = ST_SUM;
              end
            end
            MODE_SEARCH: begin
              if (amt_sw[SUM_WIDTH-1] || amt_sw == '0) begin
                res_found_next = '1;
              end else begin
                state_next = ST_SRCH;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = pos[AW-1:0];
        ram_wdata = ram_rdata + operand;
        if (add_nxt < {1'b0, n}) begin
          ram_raddr = add_nxt[AW-1:0];
          pos_next  = add_nxt;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SUM: begin
        if (rd_pend) begin
          acc_next = rd_sub ? acc - ram_rdata : acc + ram_rdata;
        end
        if (pos != '0) begin
          ram_raddr    = pos_dec[AW-1:0];
          pos_next     = pos & pos_dec;
          rd_pend_next = 1'b1;
          rd_sub_next  = on_b;
        end else if (!on_b) begin
          pos_next     = {1'b0, other_end};
          on_b_next    = 1'b1;
          rd_pend_next = 1'b0;
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SRCH: begin
        if (step == '0) begin
          res_found_next = FOUND_W'(pos);
          state_next     = ST_DONE;
        end else if (cand <= {1'b0, n}) begin
          ram_raddr  = cand_dec[AW-1:0];
          state_next = ST_SCMP;
        end else begin
          step_next = step >> 1;
        end
      end
      ST_SCMP: begin
        if ($signed(ram_rdata) < $signed(operand)) begin
          pos_next     = cand;
          operand_next = operand - ram_rdata;
        end
        step_next  = step >> 1;
        state_next = ST_SRCH;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr            <= '0;
      entries_in_use <= SIZE_RESET;
      rd_pend        <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_accept) begin
        entries_in_use <= cfg_data;
        state          <= ST_CLEAR;
        clr            <= '0;
      end else begin
        state <= state_next;
        if (state == ST_CLEAR) begin
          clr <= clr + AW'(1);
        end
      end
      rd_pend <= rd_pend_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    other_end <= other_end_next;
    on_b      <= on_b_next;
    rd_sub    <= rd_sub_next;
    acc       <= acc_next;
    operand   <= operand_next;
    step      <= step_next;
    res_found <= res_found_next;
    res_bad   <= res_bad_next;
    if (out_load) begin
      m_sum   <= sum64[AMT_W-1:0];
      m_found <= res_found;
      m_bad   <= res_bad;
    end
  end

  assign m_axis_tdata = {{(OUT_W-AMT_W-FOUND_W){1'b0}}, m_found, m_sum};
  assign m_axis_tuser = m_bad;

  a_cfg_clears : assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> state == ST_CLEAR)
    else $error("configuration write did not start the clearing pass");

  a_search_no_write : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH || state == ST_SCMP) |-> !ram_we)
    else $error("RAM written during a search");

  a_add_in_range : assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> (pos < {1'b0, n}))
    else $error("add walked beyond the size in use");

  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_DONE)
    else $error("result shown without a finished request");

endmodule

FILE: dv/fenwick_prefix_sum_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_test
// Self-checking testbench for the binary indexed prefix-sum table.
// ----------------------------------------------------------------------------
// Requests are driven on the input stream and mirrored in a behavioural
// Fenwick table kept in the testbench, which predicts every answer at the
// moment the request is accepted. Answers are compared field by field, in
// order, as they leave the output stream. The run covers field extremes,
// every mode including the unused codes, out-of-range indices, reversed
// ranges, searches on empty and filled tables, table sizes from zero to
// beyond the store, random traffic under sender gaps and receiver stalls,
// and a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_test;
  import fpst_pkg::*;

  localparam int TABLE_ENTRIES     = 1024;
  localparam int SEARCH_FIRST_STEP = 1 << 25;
  localparam int QUIET_LIMIT       = 6000;
  localparam int SETTLE_CYCLES     = 40;
  localparam mode_t MODE_SPARE_FIRST = MODE_SEARCH + 3'd1;

  typedef struct packed {
    logic [AMT_W-1:0]   sum;
    logic [FOUND_W-1:0] found;
    logic               bad;
  } table_answer_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  mode_t                s_axis_tuser = MODE_ADD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  size_t                cfg_data = '0;

  logic [AMT_W-1:0]     mirror_sums [TABLE_ENTRIES];
  int unsigned          table_size;
  table_answer_t        pending_answers[$];
  int                   fail_count = 0;
  int                   sender_idle_pct = 0;
  int                   receiver_stall_pct = 0;
  int                   hold_off_left = 0;
  int                   quiet_cycles = 0;

  fenwick_prefix_sum_table #(
    .ENTRIES  (TABLE_ENTRIES),
    .SUM_WIDTH(AMT_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- mirror
  function automatic logic [AMT_W-1:0] prefix_total(int unsigned end_pos);
    logic [AMT_W-1:0] acc;
    acc = '0;
    while (end_pos > 0) begin
      acc = acc + mirror_sums[end_pos-1];
      end_pos = end_pos & (end_pos - 1);
    end
    return acc;
  endfunction

  function automatic void clear_mirror(size_t size_value);
    foreach (mirror_sums[i]) mirror_sums[i] = '0;
    table_size = (32'(size_value) > TABLE_ENTRIES) ? TABLE_ENTRIES : 32'(size_value);
  endfunction

  function automatic table_answer_t predict_answer(mode_t mode, int unsigned first,
                                                   int unsigned second,
                                                   logic [AMT_W-1:0] amount);
    table_answer_t    answer;
    int unsigned      pos;
    int unsigned      step;
    logic [AMT_W-1:0] target;
    answer = '0;
    case (mode)
      MODE_ADD: begin
        if (first >= table_size) begin
          answer.bad = 1'b1;
        end else begin
          pos = first;
          while (pos < table_size) begin
            mirror_sums[pos] = mirror_sums[pos] + amount;
            pos = pos | (pos + 1);
          end
        end
      end
      MODE_PREFIX: begin
        if (first > table_size) answer.bad = 1'b1;
        else answer.sum = prefix_total(first);
      end
      MODE_RANGE: begin
        if (first >= table_size || second >= table_size) answer.bad = 1'b1;
        else answer.sum = prefix_total(second + 1) - prefix_total(first);
      end
      MODE_POINT: begin
        if (first >= table_size) answer.bad = 1'b1;
        else answer.sum = prefix_total(first + 1) - prefix_total(first);
      end
      MODE_SEARCH: begin
        if ($signed(amount) <= 0) begin
          answer.found = '1;
        end else begin
          pos = 0;
          target = amount;
          for (step = SEARCH_FIRST_STEP; step != 0; step = step >> 1) begin
            if (pos + step <= table_size &&
                $signed(mirror_sums[pos+step-1]) < $signed(target)) begin
              pos = pos + step;
              target = target - mirror_sums[pos-1];
            end
          end
          answer.found = pos[FOUND_W-1:0];
        end
      end
      default: ;
    endcase
    return answer;
  endfunction

  // ------------------------------------------------------------- utilities
  function automatic logic [AMT_W-1:0] random_amount();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[AMT_W-1:0];
  endfunction

  function automatic int unsigned pick_index(int unsigned upper, int unsigned field_max);
    if ($urandom_range(9) == 0) return $urandom_range(field_max);
    if (upper > field_max) upper = field_max;
    return $urandom_range(upper);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic send_request(mode_t mode, logic [IDX_W-1:0] first,
                              logic [SIDX_W-1:0] second, logic [AMT_W-1:0] amount);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, amount, second, first};
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_answers.push_back(predict_answer(mode, 32'(first), 32'(second), amount));
  endtask

  task automatic wait_for_answers();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_table_size(size_t size_value);
    wait_for_answers();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size_value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    clear_mirror(size_value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request();
    int unsigned      pick;
    logic [AMT_W-1:0] total;
    logic [AMT_W-1:0] amount;
    mode_t            mode;
    pick = $urandom_range(99);
    amount = random_amount();
    if (pick < 35) begin
      mode = MODE_ADD;
      if ($urandom_range(19) != 0) amount = AMT_W'($urandom_range(1000));
    end else if (pick < 50) begin
      mode = MODE_PREFIX;
    end else if (pick < 65) begin
      mode = MODE_RANGE;
    end else if (pick < 75) begin
      mode = MODE_POINT;
    end else if (pick < 95) begin
      mode = MODE_SEARCH;
      total = prefix_total(table_size);
      if ($signed(total) >= 0 && total < 48'h4000_0000 && $urandom_range(9) != 0)
        amount = AMT_W'($urandom_range(total[31:0] + 1));
    end else begin
      mode = mode_t'($urandom_range(7));
    end
    send_request(mode,
                 IDX_W'(pick_index(mode == MODE_PREFIX ? table_size : table_size - 1, 2047)),
                 SIDX_W'(pick_index(table_size - 1, 1023)), amount);
  endtask

  // ----------------------------------------------------------------- tests
  task automatic test_directed_after_reset();
    mode_t spare;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_request(MODE_PREFIX, 11'd0, 10'd0, '0);
    send_request(MODE_PREFIX, 11'd1024, 10'd0, '0);
    send_request(MODE_SEARCH, 11'd0, 10'd0, 48'd1);
    send_request(MODE_ADD, 11'd0, 10'd1023, 48'h7FFF_FFFF_FFFF);
    send_request(MODE_ADD, 11'd1023, 10'd0, 48'h8000_0000_0000);
    send_request(MODE_ADD, 11'd1024, 10'd0, 48'd5);
    send_request(MODE_ADD, 11'd2047, 10'd1023, 48'hFFFF_FFFF_FFFF);
    send_request(MODE_PREFIX, 11'd1024, 10'd0, '0);
    send_request(MODE_PREFIX, 11'd1025, 10'd0, '0);
    send_request(MODE_PREFIX, 11'd2047, 10'd0, '0);
    send_request(MODE_RANGE, 11'd0, 10'd1023, '0);
    send_request(MODE_RANGE, 11'd1023, 10'd0, '0);
    send_request(MODE_RANGE, 11'd1024, 10'd5, '0);
    send_request(MODE_POINT, 11'd0, 10'd0, '0);
    send_request(MODE_POINT, 11'd1023, 10'd0, '0);
    send_request(MODE_POINT, 11'd2047, 10'd0, '0);
    send_request(MODE_SEARCH, 11'd0, 10'd0, '0);
    send_request(MODE_SEARCH, 11'd0, 10'd0, 48'h8000_0000_0000);
    send_request(MODE_SEARCH, 11'd0, 10'd0, 48'h7FFF_FFFF_FFFF);
    send_request(MODE_SEARCH, 11'd2047, 10'd1023, 48'd1);
    for (spare = MODE_SPARE_FIRST; spare != MODE_ADD; spare++)
      send_request(spare, 11'd2047, 10'd1023, 48'hFFFF_FFFF_FFFF);
  endtask

  task automatic test_search_on_filled_table();
    set_table_size(SIZE_RESET);
    for (int i = 0; i < 12; i++)
      send_request(MODE_ADD, IDX_W'($urandom_range(1023)), 10'd0,
                   AMT_W'($urandom_range(1, 50)));
    send_request(MODE_SEARCH, 11'd0, 10'd0, 48'd1);
    send_request(MODE_SEARCH, 11'd0, 10'd0, prefix_total(table_size));
    send_request(MODE_SEARCH, 11'd0, 10'd0, prefix_total(table_size) + 48'd1);
    send_request(MODE_RANGE, 11'd700, 10'd200, '0);
  endtask

  task automatic test_size_extremes();
    set_table_size(11'd0);
    send_request(MODE_ADD, 11'd0, 10'd0, 48'd9);
    send_request(MODE_PREFIX, 11'd0, 10'd0, '0);
    send_request(MODE_PREFIX, 11'd1, 10'd0, '0);
    send_request(MODE_RANGE, 11'd0, 10'd0, '0);
    send_request(MODE_POINT, 11'd0, 10'd0, '0);
    send_request(MODE_SEARCH, 11'd0, 10'd0, 48'd5);
    send_request(MODE_SEARCH, 11'd0, 10'd0, '0);
    set_table_size(11'd1);
    send_request(MODE_ADD, 11'd0, 10'd0, 48'd3);
    send_request(MODE_ADD, 11'd1, 10'd0, 48'd3);
    send_request(MODE_POINT, 11'd0, 10'd0, '0);
    send_request(MODE_RANGE, 11'd0, 10'd0, '0);
    send_request(MODE_RANGE, 11'd0, 10'd1, '0);
    send_request(MODE_SEARCH, 11'd0, 10'd0, 48'd3);
    send_request(MODE_SEARCH, 11'd0, 10'd0, 48'd4);
    set_table_size(11'd2047);
    send_request(MODE_ADD, 11'd1023, 10'd0, 48'd8);
    send_request(MODE_PREFIX, 11'd1024, 10'd0, '0);
    send_request(MODE_SEARCH, 11'd0, 10'd0, 48'd8);
    send_request(MODE_POINT, 11'd1024, 10'd0, '0);
  endtask

  task automatic test_random_traffic(size_t size_value, int count, int idle_pct,
                                     int stall_pct);
    set_table_size(size_value);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_random_request();
  endtask

  task automatic test_output_backpressure();
    set_table_size(11'd64);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_left = 400;
    repeat (40) send_random_request();
  endtask

  // --------------------------------------------------------------- drivers
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : check_answers
    table_answer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[47:0] !== want.sum)
          report_mismatch($sformatf("sum_result got %0d want %0d",
                                    $signed(m_axis_tdata[47:0]), $signed(want.sum)));
        if (m_axis_tdata[59:48] !== want.found)
          report_mismatch($sformatf("found_position got %0d want %0d",
                                    $signed(m_axis_tdata[59:48]), $signed(want.found)));
        if (m_axis_tuser !== want.bad)
          report_mismatch($sformatf("bad_index got %b want %b", m_axis_tuser, want.bad));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_mirror(SIZE_RESET);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_after_reset();
    test_search_on_filled_table();
    test_size_extremes();
    test_random_traffic(SIZE_RESET, 110, 0, 0);
    test_random_traffic(11'd7, 110, 84, 0);
    test_random_traffic(11'd300, 110, 0, 84);
    test_random_traffic(11'd1000, 110, 15, 15);
    test_output_backpressure();
    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
